@@ src/clock_sweep_page_cache_defines.svh @@
// Assertion macros for the clock sweep page cache.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef CLOCK_SWEEP_PAGE_CACHE_DEFINES_SVH
`define CLOCK_SWEEP_PAGE_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define CSPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CSPC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CSPC_ASSERT(label, prop, msg)
`define CSPC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ src/cspc_pkg.sv @@
// Shared constants, types and helpers for the clock sweep page cache.
// No dependencies; used by the interfaces and the top level.
package cspc_pkg;

	localparam int NUM_FRAMES  = 8;
	localparam int PAGE_BITS   = 16;
	localparam int FRAME_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int PAGE_ID_W   = 16;
	localparam int FRAME_OUT_W = 3;
	localparam int COUNT_W     = 32;

	typedef logic [PAGE_BITS-1:0]   page_t;
	typedef logic [FRAME_W-1:0]     frame_idx_t;
	typedef logic [PAGE_ID_W-1:0]   page_id_t;
	typedef logic [FRAME_OUT_W-1:0] frame_out_t;
	typedef logic [COUNT_W-1:0]     count_t;

	localparam frame_idx_t LAST_FRAME = frame_idx_t'(NUM_FRAMES - 1);

	// Step the clock hand, wrapping after the last frame.
	function automatic frame_idx_t hand_advance(input frame_idx_t h);
		return (h == LAST_FRAME) ? '0 : h + frame_idx_t'(1);
	endfunction

endpackage

@@ src/cspc_access_if.sv @@
// Access channel: one page access per transfer.
// Depends on cspc_pkg.
interface cspc_access_if;
	logic               valid;
	logic               ready;
	cspc_pkg::page_id_t page_id;

	modport source (output valid, output page_id, input ready);
	modport sink (input valid, input page_id, output ready);
endinterface

@@ src/cspc_result_if.sv @@
// Result channel: one lookup outcome per transfer.
// Depends on cspc_pkg.
interface cspc_result_if;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	cspc_pkg::frame_out_t frame;
	logic                 evicted;
	cspc_pkg::page_id_t   evicted_page;
	cspc_pkg::count_t     hit_count;
	cspc_pkg::count_t     miss_count;
	cspc_pkg::count_t     eviction_count;

	modport source (output valid, output hit, output frame, output evicted,
		output evicted_page, output hit_count, output miss_count,
		output eviction_count, input ready);
	modport sink (input valid, input hit, input frame, input evicted,
		input evicted_page, input hit_count, input miss_count,
		input eviction_count, output ready);
endinterface

@@ src/clock_sweep_page_cache.sv @@
// A hit ends the search at the matching frame; a miss searches every frame and fills the
// lowest empty one or, when all frames are valid, sweeps the clock hand to a frame whose
// reference bit is clear. Accesses are taken only in idle, one at a time; the page-tag RAM
// port reads one frame per cycle, which sets both the search and the victim read.
// Reset clears valid and reference bits, hand and counters; the tag RAM is not cleared.
`include "clock_sweep_page_cache_defines.svh"

module clock_sweep_page_cache (
	input  logic           clk,
	input  logic           arst_n,
	cspc_access_if.sink    access,
	cspc_result_if.source  result
);
	import cspc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SWEEP,
		ST_COMMIT
	} state_t;

	state_t          state_q;
	page_t           page_q;
	frame_idx_t      idx_q;
	frame_idx_t      slot_q;
	frame_idx_t      first_empty_q;
	logic            empty_found_q;
	logic            hit_q;
	logic            evict_q;
	frame_idx_t      hand_q;
	logic [NUM_FRAMES-1:0] valid_q;
	logic [NUM_FRAMES-1:0] ref_q;
	count_t          hits_q;
	count_t          misses_q;
	count_t          evictions_q;

	// page tag RAM, registered read
	page_t           tag_mem [NUM_FRAMES];
	page_t           rdata_q;
	logic            rd_en;
	frame_idx_t      rd_addr;

	logic            out_vld_q;
	logic            out_hit_q;
	frame_out_t      out_frame_q;
	logic            out_ev_q;
	page_id_t        out_ev_page_q;
	count_t          out_hits_q;
	count_t          out_misses_q;
	count_t          out_evictions_q;

	logic            out_free;
	logic            commit_fire;
	logic            hit_now;
	count_t          hits_nxt;
	count_t          misses_nxt;
	count_t          evictions_nxt;

	assign out_free    = !out_vld_q || result.ready;
	assign commit_fire = (state_q == ST_COMMIT) && out_free;
	assign hit_now     = valid_q[idx_q] && (rdata_q == page_q);
	assign access.ready = (state_q == ST_IDLE);

	assign hits_nxt      = hit_q ? hits_q + count_t'(1) : hits_q;
	assign misses_nxt    = hit_q ? misses_q : misses_q + count_t'(1);
	assign evictions_nxt = evict_q ? evictions_q + count_t'(1) : evictions_q;

	// Read address per state; writes only happen in commit, so reads never collide.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				rd_en   = access.valid;
				rd_addr = '0;
			end
			ST_SEARCH: begin
				rd_en   = !hit_now && (idx_q != LAST_FRAME);
				rd_addr = idx_q + frame_idx_t'(1);
			end
			ST_SWEEP: begin
				rd_en   = !ref_q[hand_q];
				rd_addr = hand_q;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (commit_fire && !hit_q) begin
			tag_mem[slot_q] <= page_q;
		end
		if (rd_en) begin
			rdata_q <= tag_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			ref_q       <= '0;
			hand_q      <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evictions_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (commit_fire) begin
				out_vld_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (access.valid) begin
						page_q        <= page_t'(access.page_id);
						idx_q         <= '0;
						empty_found_q <= 1'b0;
						state_q       <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// remember the lowest empty frame in case this turns out a miss
					if (!valid_q[idx_q] && !empty_found_q) begin
						empty_found_q <= 1'b1;
						first_empty_q <= idx_q;
					end
					if (hit_now) begin
						hit_q   <= 1'b1;
						evict_q <= 1'b0;
						slot_q  <= idx_q;
						state_q <= ST_COMMIT;
					end else if (idx_q == LAST_FRAME) begin
						hit_q <= 1'b0;
						if (empty_found_q || !valid_q[idx_q]) begin
							evict_q <= 1'b0;
							slot_q  <= empty_found_q ? first_empty_q : idx_q;
							state_q <= ST_COMMIT;
						end else begin
							state_q <= ST_SWEEP;
						end
					end else begin
						idx_q <= idx_q + frame_idx_t'(1);
					end
				end
				ST_SWEEP: begin
					// second chance: clear and advance, or take the frame under the hand
					hand_q <= hand_advance(hand_q);
					if (ref_q[hand_q]) begin
						ref_q[hand_q] <= 1'b0;
					end else begin
						slot_q  <= hand_q;
						evict_q <= 1'b1;
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						valid_q[slot_q]  <= 1'b1;
						ref_q[slot_q]    <= hit_q;
						hits_q           <= hits_nxt;
						misses_q         <= misses_nxt;
						evictions_q      <= evictions_nxt;
						out_hit_q        <= hit_q;
						out_frame_q      <= frame_out_t'(slot_q);
						out_ev_q         <= evict_q;
						out_ev_page_q    <= evict_q ? page_id_t'(rdata_q) : '0;
						out_hits_q       <= hits_nxt;
						out_misses_q     <= misses_nxt;
						out_evictions_q  <= evictions_nxt;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid          = out_vld_q;
	assign result.hit            = out_hit_q;
	assign result.frame          = out_frame_q;
	assign result.evicted        = out_ev_q;
	assign result.evicted_page   = out_ev_page_q;
	assign result.hit_count      = out_hits_q;
	assign result.miss_count     = out_misses_q;
	assign result.eviction_count = out_evictions_q;

	`CSPC_ASSERT(a_hand_range, (32'(hand_q) < 32'(NUM_FRAMES)), "clock hand out of range")
	`CSPC_ASSERT(a_sweep_full, (state_q == ST_SWEEP) |-> (&valid_q), "sweep with an empty frame")
	`CSPC_ASSERT(a_fill_valid, (commit_fire && !hit_q) |=> valid_q[$past(slot_q)], "filled frame not valid")
	`CSPC_ASSERT(a_one_count, commit_fire |=> ((hits_q != $past(hits_q)) != (misses_q != $past(misses_q))), "hit and miss counters out of step")
	`CSPC_ASSERT(a_hit_no_evict, result.valid |-> !(result.hit && result.evicted), "eviction reported on a hit")

endmodule
